// ----- rtl/positional_list_engine_assert.svh -----
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define PLE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ple assertion failed");

`define PLE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ple forbidden condition");

`else

`define PLE_ASSERT(lbl, clk, rst_n, prop)

`define PLE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/ple_pkg.sv -----
// Types and constants shared by the positional list engine modules.
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 16;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 40;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_INSERT     = 3'd2,
		REQ_ERASE      = 3'd3,
		REQ_READ       = 3'd4
	} req_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_CLAMP = 3'd1,
		ST_NEG   = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_ERASE,
		OP_READ
	} op_e;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_e;

	typedef struct packed {
		logic             load;
		op_e              op;
		logic [IDX_W-1:0] idx;
		status_e          status;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} dp_stat_t;

endpackage

// ----- rtl/ple_ctrl.sv -----
// Controller: request decode, position checks and output word handshake.
module ple_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [ple_pkg::REQ_W-1:0]  req_type,
	input  logic [ple_pkg::POS_W-1:0]  position,
	input  ple_pkg::dp_stat_t          stat,
	output ple_pkg::cmd_t              cmd,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready
);
	import ple_pkg::*;

	state_e           state_q;
	state_e           state_d;
	logic             accept;
	logic             pos_neg;
	logic             pos_zero;
	logic             pos_ge;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] last_idx;
	op_e              op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b1;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				m_axis_tvalid = 1'b0;
				if (s_axis_tvalid) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				s_axis_tready = m_axis_tready;
				m_axis_tvalid = 1'b1;
				if (m_axis_tready && !s_axis_tvalid) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign pos_neg  = position[POS_W-1];
	assign pos_zero = (position == '0);
	assign pos_ge   = (position >= POS_W'(stat.count));
	assign pos_idx  = position[IDX_W-1:0];
	assign tail_idx = stat.count[IDX_W-1:0];
	assign last_idx = IDX_W'(stat.count - CNT_W'(1));

	always_comb begin
		op_d       = OP_NONE;
		cmd.idx    = '0;
		cmd.status = ST_OK;
		unique case (req_e'(req_type))
			REQ_PUSH_FRONT: begin
				if (stat.full) begin
					cmd.status = ST_FULL;
				end else begin
					op_d = OP_INSERT;
				end
			end
			REQ_PUSH_BACK: begin
				if (stat.full) begin
					cmd.status = ST_FULL;
				end else begin
					op_d    = OP_INSERT;
					cmd.idx = tail_idx;
				end
			end
			REQ_INSERT: begin
				priority if (pos_neg) begin
					cmd.status = ST_NEG;
				end else if (stat.full) begin
					cmd.status = ST_FULL;
				end else if (pos_zero) begin
					op_d = OP_INSERT;
				end else if (pos_ge) begin
					op_d       = OP_INSERT;
					cmd.idx    = tail_idx;
					cmd.status = ST_CLAMP;
				end else begin
					op_d    = OP_INSERT;
					cmd.idx = pos_idx;
				end
			end
			REQ_ERASE: begin
				priority if (pos_neg) begin
					cmd.status = ST_NEG;
				end else if (stat.empty) begin
					cmd.status = ST_EMPTY;
				end else if (pos_ge) begin
					op_d       = OP_ERASE;
					cmd.idx    = last_idx;
					cmd.status = ST_CLAMP;
				end else begin
					op_d    = OP_ERASE;
					cmd.idx = pos_idx;
				end
			end
			REQ_READ: begin
				priority if (pos_neg) begin
					cmd.status = ST_NEG;
				end else if (stat.empty) begin
					cmd.status = ST_EMPTY;
				end else if (pos_ge) begin
					op_d       = OP_READ;
					cmd.idx    = last_idx;
					cmd.status = ST_CLAMP;
				end else begin
					op_d    = OP_READ;
					cmd.idx = pos_idx;
				end
			end
			default: begin
				op_d = OP_NONE;
			end
		endcase
		cmd.load = accept;
		cmd.op   = accept ? op_d : OP_NONE;
	end

endmodule

// ----- rtl/ple_dp.sv -----
// Datapath: entry register cells with parallel shift, count and result word.
module ple_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ple_pkg::cmd_t                 cmd,
	input  logic [ple_pkg::VALUE_W-1:0]   value,
	output ple_pkg::dp_stat_t             stat,
	output logic [ple_pkg::STATUS_W-1:0]  status,
	output logic [ple_pkg::VALUE_W-1:0]   read_value,
	output logic [ple_pkg::COUNT_W-1:0]   count
);
	import ple_pkg::*;

	logic [VALUE_W-1:0]  entries_q [CAPACITY];
	logic [VALUE_W-1:0]  entries_d [CAPACITY];
	logic [CAPACITY-1:0] entry_we;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [VALUE_W-1:0]  rd_sel;
	status_e             res_status_q;
	logic [VALUE_W-1:0]  res_rd_q;
	logic [COUNT_W-1:0]  res_count_q;

	assign stat.count = count_q;
	assign stat.full  = (count_q >= CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VALUE_W-1:0] prev_val;
		logic [VALUE_W-1:0] next_val;

		if (g == 0) begin : g_first
			assign prev_val = '0;
		end else begin : g_mid
			assign prev_val = entries_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign next_val = '0;
		end else begin : g_body
			assign next_val = entries_q[g+1];
		end

		always_comb begin
			entry_we[g]  = 1'b0;
			entries_d[g] = entries_q[g];
			unique case (cmd.op)
				OP_INSERT: begin
					if (IDX_W'(g) == cmd.idx) begin
						entry_we[g]  = 1'b1;
						entries_d[g] = value;
					end else if (IDX_W'(g) > cmd.idx && CNT_W'(g) <= count_q) begin
						entry_we[g]  = 1'b1;
						entries_d[g] = prev_val;
					end
				end
				OP_ERASE: begin
					if (IDX_W'(g) >= cmd.idx && (CNT_W'(g) + CNT_W'(1)) < count_q) begin
						entry_we[g]  = 1'b1;
						entries_d[g] = next_val;
					end
				end
				OP_NONE, OP_READ: begin
					entry_we[g] = 1'b0;
				end
				default: begin
					entry_we[g] = 1'b0;
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (entry_we[g]) begin
				entries_q[g] <= entries_d[g];
			end
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_INSERT: count_d = count_q + CNT_W'(1);
			OP_ERASE:  count_d = count_q - CNT_W'(1);
			default:   count_d = count_q;
		endcase
	end

	assign rd_sel = (cmd.op == OP_READ) ? entries_q[cmd.idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= cmd.status;
			res_rd_q     <= rd_sel;
			res_count_q  <= COUNT_W'(count_d);
		end
	end

	assign status     = res_status_q;
	assign read_value = res_rd_q;
	assign count      = res_count_q;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Positional list engine top level: stream ports, controller and datapath.
//
// Holds an ordered list of up to 16 signed 32-bit entries. Each input word is
// one request (push front, push back, insert, erase or read at a position) and
// produces exactly one output word with status, read value and the count after
// the request. The entries sit in register cells that all shift at once toward
// or away from the position, so an input word is accepted every cycle while
// the output is drained, and its result appears in the output register on the
// next cycle. Backpressure on the output stalls input only while a result is
// held unread.
`include "positional_list_engine_assert.svh"

module positional_list_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ple_pkg::IN_W-1:0]     s_axis_tdata,  // value[31:0], position[47:32]
	input  logic [ple_pkg::REQ_W-1:0]    s_axis_tuser,  // req_type[2:0]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ple_pkg::OUT_W-1:0]    m_axis_tdata,  // read_value[31:0], count[36:32]
	output logic [ple_pkg::STATUS_W-1:0] m_axis_tuser   // status[2:0]
);
	import ple_pkg::*;

	cmd_t               cmd;
	dp_stat_t           stat;
	logic [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0] count;

	ple_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.req_type      (s_axis_tuser),
		.position      (s_axis_tdata[VALUE_W +: POS_W]),
		.stat          (stat),
		.cmd           (cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	ple_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (s_axis_tdata[VALUE_W-1:0]),
		.stat       (stat),
		.status     (m_axis_tuser),
		.read_value (read_value),
		.count      (count)
	);

	assign m_axis_tdata = {(OUT_W - VALUE_W - COUNT_W)'(0), count, read_value};

	`PLE_ASSERT(a_insert_grows, clk, arst_n, cmd.op == OP_INSERT |=> stat.count == $past(stat.count) + CNT_W'(1))
	`PLE_ASSERT(a_erase_shrinks, clk, arst_n, cmd.op == OP_ERASE |=> stat.count == $past(stat.count) - CNT_W'(1))
	`PLE_ASSERT(a_stall_only_held, clk, arst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
	`PLE_ASSERT_NEVER(a_full_count, clk, arst_n, m_axis_tvalid && m_axis_tuser == ST_FULL && count != COUNT_W'(CAPACITY))

endmodule
